[rtl/owu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package owu_pkg;

  localparam int unsigned ACC_W   = 48;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned PROD_W  = ACC_W + DATA_W;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned ROOT_W  = 32;
  localparam int unsigned DEN_W   = ROOT_W + 1;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] MUL_LONG   = 6'd32;
  localparam logic [CNT_W-1:0] MUL_SHORT  = 6'd16;
  localparam logic [CNT_W-1:0] SQRT_STEPS = 6'd32;
  localparam logic [CNT_W-1:0] DIV_STEPS  = 6'd48;

  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LR       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOMENTUM = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON  = 2'd3;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_MOM   = 2'd1;
  localparam logic [1:0] MODE_ADA   = 2'd2;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_READ, ST_MUL1, ST_MUL2, ST_SQRT, ST_DIV, ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    PATH_PASS, PATH_CLEAR, PATH_PLAIN, PATH_MOM, PATH_ADA
  } path_e;

endpackage
`default_nettype wire

[rtl/owu_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface owu_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [9:0]         slot;
  logic signed [31:0] weight;
  logic signed [31:0] gradient;
  modport source (output valid, opcode, slot, weight, gradient, input ready);
  modport sink (input valid, opcode, slot, weight, gradient, output ready);
endinterface

interface owu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_weight;
  logic               saturated;
  modport source (output valid, new_weight, saturated, input ready);
  modport sink (input valid, new_weight, saturated, output ready);
endinterface
`default_nettype wire

[rtl/owu_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
module owu_mul import owu_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              short_i,
  input  wire logic [ACC_W-1:0]  a_i,
  input  wire logic [DATA_W-1:0] b_i,
  output logic                   done_o,
  output logic [PROD_W-1:0]      prod_o
);

  logic             busy_q, done_q, short_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0] a_q, acc_q;
  logic [DATA_W-1:0] b_q, lo_q;
  logic [ACC_W:0]   sum;

  // one multiplier bit per cycle, lsb first
  assign sum = {1'b0, acc_q} + (b_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= short_i ? MUL_SHORT : MUL_LONG;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q     <= a_i;
      b_q     <= b_i;
      acc_q   <= '0;
      lo_q    <= '0;
      short_q <= short_i;
    end else if (busy_q) begin
      acc_q <= sum[ACC_W:1];
      lo_q  <= {sum[0], lo_q[DATA_W-1:1]};
      b_q   <= {1'b0, b_q[DATA_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = short_q ? {16'b0, acc_q, lo_q[DATA_W-1:FRAC_W]} : {acc_q, lo_q};

endmodule
`default_nettype wire

[rtl/owu_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
module owu_sqrt import owu_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [2*ROOT_W-1:0]   n_i,
  output logic                       done_o,
  output logic [ROOT_W-1:0]          root_o
);

  logic                busy_q, done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [2*ROOT_W-1:0] n_q;
  logic [ROOT_W+1:0]   r_q;
  logic [ROOT_W-1:0]   root_q;
  logic [ROOT_W+3:0]   rr, trial, diff;
  logic                take;

  // bring down two radicand bits, try root*4+1
  assign rr    = {r_q, n_q[2*ROOT_W-1 -: 2]};
  assign trial = {2'b0, root_q, 2'b01};
  assign take  = rr >= trial;
  assign diff  = rr - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= SQRT_STEPS;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= n_i;
      r_q    <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      n_q    <= {n_q[2*ROOT_W-3:0], 2'b00};
      r_q    <= take ? diff[ROOT_W+1:0] : rr[ROOT_W+1:0];
      root_q <= {root_q[ROOT_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

[rtl/owu_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module owu_div import owu_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [ACC_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [ACC_W-1:0]      quo_o
);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0] q_q;
  logic [DEN_W-1:0] den_q, rem_q;
  logic [DEN_W:0]   t, diff;
  logic             take;

  // restoring division, one quotient bit per cycle
  assign t    = {rem_q, q_q[ACC_W-1]};
  assign take = t >= {1'b0, den_q};
  assign diff = t - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_STEPS;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? diff[DEN_W-1:0] : t[DEN_W-1:0];
      q_q   <= {q_q[ACC_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;

endmodule
`default_nettype wire

[rtl/optimizer_weight_update.sv]
// optimizer_weight_update: one optimizer step per request, Q16.16 fixed point.
// in_i carries opcode, slot, weight and gradient; out_o returns new_weight
// and a saturated flag, one result per request, in order.
// cfg_we_i/cfg_idx_i/cfg_data_i write mode, learning_rate, momentum_factor
// and epsilon (index 0..3); write them only while the block is idle.
// Work from accept to result valid, done by the serial units:
//   clear, pass-through:  no serial unit
//   plain descent:        one 16-bit serial multiply
//   momentum:             two 16-bit serial multiplies
//   adagrad:              32 + 16 bit multiplies, 32-step root,
//                         48-step divide
// One request is in flight at a time; the next can be taken in the cycle
// after the previous result is loaded into the output register.
// After reset the accumulator memory is swept to zero, one slot per cycle,
// over all DEPTH slots (at most 1024); in_i.ready stays low during the sweep.
// A stalled receiver holds the result in the output register; one more
// request may be accepted and worked on, and it waits in its final step
// until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none
module optimizer_weight_update import owu_pkg::*; #(
  parameter int unsigned SLOTS = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  owu_in_if.sink                    in_i,
  owu_out_if.source                 out_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [15:0]          cfg_data_i
);

  localparam int unsigned DEPTH = (SLOTS < 1024) ? SLOTS : 1024;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [16:0] SLOTS_W = 17'(SLOTS);
  localparam logic signed [49:0] S48_MAX = 50'sd140737488355327;
  localparam logic signed [49:0] S48_MIN = -S48_MAX - 50'sd1;
  localparam logic signed [49:0] S32_MAX = 50'sd2147483647;
  localparam logic signed [49:0] S32_MIN = -S32_MAX - 50'sd1;

  // configuration
  logic [1:0]  mode_q;
  logic [15:0] lr_q, mom_q, eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      lr_q   <= 16'd655;
      mom_q  <= 16'd58982;
      eps_q  <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:     mode_q <= cfg_data_i[1:0];
        REG_LR:       lr_q   <= cfg_data_i;
        REG_MOMENTUM: mom_q  <= cfg_data_i;
        REG_EPSILON:  eps_q  <= cfg_data_i;
        default:      mode_q <= mode_q;
      endcase
    end
  end

  state_e state_q, state_d;
  path_e  path_q, path_d;
  logic   in_ready, accept, fin_go;
  logic [AW-1:0] clr_q;

  // captured request
  logic               op_q;
  logic [9:0]         slot_q;
  logic signed [31:0] w_q, g_q;
  logic               in_range;
  logic [DATA_W-1:0]  gmag;

  // accumulator memory
  logic [ACC_W-1:0] mem [DEPTH];
  logic [ACC_W-1:0] rd_q, wr_data;
  logic [AW-1:0]    wr_addr;
  logic             wr_en;

  // serial units
  logic              mul_start, mul_short, mul_done;
  logic [ACC_W-1:0]  mul_a;
  logic [DATA_W-1:0] mul_b;
  logic [PROD_W-1:0] prod;
  logic              sqrt_start, sqrt_done;
  logic [ROOT_W-1:0] root;
  logic              div_start, div_done;
  logic [DEN_W-1:0]  den;
  logic [ACC_W-1:0]  quo;

  logic [ACC_W-1:0]  vm_q, h_q, num_q, vmag;
  logic [ACC_W:0]    hsum;
  logic              hsat_q;

  assign in_range = {7'b0, slot_q} < SLOTS_W;
  assign gmag     = g_q[31] ? 32'(-g_q) : g_q;
  assign vmag     = rd_q[ACC_W-1] ? (~rd_q + 1'b1) : rd_q;
  assign hsum     = {1'b0, rd_q} + {1'b0, prod[63:16]};
  assign in_ready = (state_q == ST_IDLE);
  assign accept   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  always_comb begin
    logic [DEN_W-1:0] den_raw;
    den_raw = {1'b0, root} + DEN_W'(eps_q);
    den     = (den_raw == '0) ? DEN_W'(1) : den_raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      path_q  <= PATH_PASS;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      path_q  <= path_d;
      if (state_q == ST_CLR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    path_d     = path_q;
    mul_start  = 1'b0;
    mul_short  = 1'b1;
    mul_a      = {16'b0, gmag};
    mul_b      = {16'b0, lr_q};
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    case (state_q)
      ST_CLR: begin
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_FIN;
        path_d  = PATH_PASS;
        if (op_q == OP_CLEAR) begin
          path_d = PATH_CLEAR;
        end else begin
          case (mode_q)
            MODE_PLAIN: begin
              path_d    = PATH_PLAIN;
              mul_start = 1'b1;
              state_d   = ST_MUL1;
            end
            MODE_MOM: begin
              if (in_range) begin
                path_d    = PATH_MOM;
                mul_start = 1'b1;
                mul_a     = vmag;
                mul_b     = {16'b0, mom_q};
                state_d   = ST_MUL1;
              end
            end
            MODE_ADA: begin
              if (in_range) begin
                path_d    = PATH_ADA;
                mul_start = 1'b1;
                mul_short = 1'b0;
                mul_b     = gmag;
                state_d   = ST_MUL1;
              end
            end
            default: path_d = PATH_PASS;
          endcase
        end
      end
      ST_MUL1: begin
        if (mul_done) begin
          if (path_q == PATH_PLAIN) begin
            state_d = ST_FIN;
          end else begin
            mul_start = 1'b1;
            state_d   = ST_MUL2;
          end
        end
      end
      ST_MUL2: begin
        if (mul_done) begin
          if (path_q == PATH_ADA) begin
            sqrt_start = 1'b1;
            state_d    = ST_SQRT;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_i.opcode;
      slot_q <= in_i.slot;
      w_q    <= in_i.weight;
      g_q    <= in_i.gradient;
    end
    if (state_q == ST_MUL1 && mul_done) begin
      vm_q <= prod[63:16];
      h_q  <= hsum[ACC_W] ? '1 : hsum[ACC_W-1:0];
    end
    if (state_q == ST_MUL2 && mul_done) begin
      num_q <= prod[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsat_q <= 1'b0;
    end else if (state_q == ST_READ) begin
      hsat_q <= 1'b0;
    end else if (state_q == ST_MUL1 && mul_done && path_q == PATH_ADA) begin
      hsat_q <= hsum[ACC_W];
    end
  end

  // final combine and clamps
  logic signed [49:0] wext, gstep, qstep, vterm, vsum, v48, nwx;
  logic [49:0]        t50, q50, vm50;
  logic               vsat, wsat;
  logic signed [31:0] nw;

  always_comb begin
    wext  = {{18{w_q[31]}}, w_q};
    t50   = {19'b0, prod[46:16]};
    gstep = g_q[31] ? -$signed(t50) : $signed(t50);
    q50   = {2'b0, quo};
    qstep = g_q[31] ? -$signed(q50) : $signed(q50);
    vm50  = {2'b0, vm_q};
    vterm = rd_q[ACC_W-1] ? -$signed(vm50) : $signed(vm50);
    vsum  = vterm - gstep;
    vsat  = 1'b0;
    if (vsum > S48_MAX) begin
      v48  = S48_MAX;
      vsat = 1'b1;
    end else if (vsum < S48_MIN) begin
      v48  = S48_MIN;
      vsat = 1'b1;
    end else begin
      v48 = vsum;
    end
    case (path_q)
      PATH_PLAIN: nwx = wext - gstep;
      PATH_MOM:   nwx = wext + v48;
      PATH_ADA:   nwx = wext - qstep;
      default:    nwx = wext;
    endcase
    wsat = 1'b0;
    if (nwx > S32_MAX) begin
      nw   = 32'sh7FFF_FFFF;
      wsat = 1'b1;
    end else if (nwx < S32_MIN) begin
      nw   = 32'sh8000_0000;
      wsat = 1'b1;
    end else begin
      nw = nwx[31:0];
    end
  end

  assign fin_go = (state_q == ST_FIN) && (!out_o.valid || out_o.ready);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_q[AW-1:0];
    wr_data = '0;
    if (state_q == ST_CLR) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
    end else if (fin_go) begin
      case (path_q)
        PATH_CLEAR: wr_en = in_range;
        PATH_MOM: begin
          wr_en   = 1'b1;
          wr_data = v48[ACC_W-1:0];
        end
        PATH_ADA: begin
          wr_en   = 1'b1;
          wr_data = h_q;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_q <= mem[in_i.slot[AW-1:0]];
    end
  end

  // output register
  logic               out_valid_q, out_sat_q;
  logic signed [31:0] out_nw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_nw_q  <= nw;
      out_sat_q <= wsat | (path_q == PATH_MOM && vsat) | (path_q == PATH_ADA && hsat_q);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.new_weight = out_nw_q;
  assign out_o.saturated  = out_sat_q;

  owu_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .short_i (mul_short),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  owu_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .n_i     ({h_q, 16'b0}),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  owu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> !in_i.ready) else $error("request taken during sweep");

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_READ)) else $error("accept not followed by read");

  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_MUL1 || state_q == ST_MUL2))
    else $error("multiply done outside multiply step");

  a_sqrt_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> (state_q == ST_SQRT)) else $error("root done outside root step");

  a_fin_write_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_go && (path_q == PATH_MOM || path_q == PATH_ADA)) |-> in_range)
    else $error("accumulator write for slot out of range");

endmodule
`default_nettype wire
